// ===== design/fdd_pkg.sv =====
// Shared constants, types, divider step and quotient finish for the deconvolution update pipeline.
package fdd_pkg;

    localparam int DATA_W    = 32;
    localparam int MAG_W     = 31;
    localparam int DEN_W     = 33;
    localparam int PROD_W    = 64;
    localparam int DIV_STEPS = 32;
    // product, partial sum, difference, magnitude and divider-init stages
    localparam int FRONT_STG = 5;
    localparam int NSTG      = FRONT_STG + DIV_STEPS;

    localparam logic [DATA_W-1:0] COND_RESET = 32'd6554;
    localparam logic [DATA_W-1:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [DATA_W-1:0] sh;
    } t_step;

    typedef struct packed {
        logic [DEN_W-1:0]  rem_re;
        logic [DEN_W-1:0]  rem_im;
        logic [DATA_W-1:0] sh_re;
        logic [DATA_W-1:0] sh_im;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
    } t_div;

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              zero;
        logic              sat;
        logic              last;
    } t_res;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_step div_step(input logic [DEN_W-1:0] rem,
                                       input logic [DATA_W-1:0] sh,
                                       input logic [DEN_W-1:0] den);
        logic [DEN_W:0] cat;
        logic [DEN_W:0] dif;
        logic           fit;
        t_step          res;
        cat     = {rem, sh[DATA_W-1]};
        dif     = cat - {1'b0, den};
        fit     = (cat >= {1'b0, den});
        res.rem = fit ? dif[DEN_W-1:0] : cat[DEN_W-1:0];
        res.sh  = {sh[DATA_W-2:0], fit};
        return res;
    endfunction

    // apply sign, truncation toward zero and saturation to one quotient
    function automatic logic [DATA_W:0] finish(input logic [DATA_W-1:0] q,
                                               input logic neg,
                                               input logic ovf);
        logic              sat;
        logic [DATA_W-1:0] val;
        if (neg) begin
            sat = ovf || (q > NEG_MIN);
            val = sat ? NEG_MIN : (~q + 32'd1);
        end else begin
            sat = ovf || q[DATA_W-1];
            val = sat ? POS_MAX : q;
        end
        return {sat, val};
    endfunction

endpackage

// ===== design/frequency_domain_deconvolution_update.sv =====
// Top level: pipelined per-bin regularized deconvolution update with a 32-stage divider.
//
// Usage
//   Input channel: i_valid / o_stall carry one frequency bin per request (image,
//   point-spread, transfer magnitude, current estimate, last-bin mark). A request
//   is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one updated estimate per request, with
//   zero-divisor, saturation and last-bin flags, in input order.
//   Config: i_cfg_wr_en / i_cfg_wr_data write the conditioning value added to the
//   transfer magnitude; write it only while the pipeline is empty.
//   Pipeline: 38 registers from the accepting edge to o_valid (5 arithmetic
//   stages, 32 divider stages of one quotient bit each, one output register; the
//   first loads at the accepting edge).
//   Throughput: one request per cycle while o_stall is low, set by the one-bit-per-stage divider chain.
//   Reset (synchronous, active low) empties the pipeline, drops any held result
//   and sets the conditioning value to 6554.
//   Receiver stall: the output register holds; one more result lands in a skid
//   register, after which o_stall rises (registered) and the whole pipeline holds
//   until the skid register drains. Nothing is lost or repeated.
module frequency_domain_deconvolution_update import fdd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [DATA_W-1:0]        i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_image_real,
    input  logic signed [DATA_W-1:0] i_image_imag,
    input  logic signed [DATA_W-1:0] i_spread_real,
    input  logic signed [DATA_W-1:0] i_spread_imag,
    input  logic        [MAG_W-1:0]  i_transfer_mag,
    input  logic signed [DATA_W-1:0] i_estimate_real,
    input  logic signed [DATA_W-1:0] i_estimate_imag,
    input  logic                     i_last_bin,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_updated_real,
    output logic signed [DATA_W-1:0] o_updated_imag,
    output logic                     o_zero_divisor,
    output logic                     o_saturated,
    output logic                     o_last_out
);

    logic [DATA_W-1:0] r_cond;
    logic [NSTG-1:0]   r_vld;
    logic [DEN_W-1:0]  r_den  [NSTG];
    logic              r_last [NSTG];

    // stage 0: products
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    // stage 1: partial sums
    logic signed [PROD_W:0]   r_sa_re, r_sa_im;
    logic signed [PROD_W-1:0] r_q2, r_q5;
    // stage 2: full numerators
    logic signed [PROD_W+1:0] r_n_re, r_n_im;
    // stage 3: sign and magnitude
    logic [PROD_W-1:0]        r_mag_re, r_mag_im;
    logic                     r_neg_re, r_neg_im;
    // stage 4 onward: divider
    t_div                     r_div [DIV_STEPS+1];
    t_div                     n_div [DIV_STEPS+1];

    t_res  r_out, r_skid, n_res;
    logic  r_out_v, r_skid_v;
    logic  en;
    logic  take_ok;

    logic signed [PROD_W+1:0] n_abs_re, n_abs_im;
    logic [DATA_W:0]          fin_re, fin_im;
    logic                     den_zero;

    assign en      = !r_skid_v;
    assign take_ok = !r_out_v || !i_stall;
    assign o_stall = r_skid_v;

    always_comb begin
        n_abs_re = r_n_re[PROD_W+1] ? -r_n_re : r_n_re;
        n_abs_im = r_n_im[PROD_W+1] ? -r_n_im : r_n_im;
    end

    always_comb begin
        t_step s_re;
        t_step s_im;
        n_div[0].rem_re = {1'b0, r_mag_re[PROD_W-1:DATA_W]};
        n_div[0].rem_im = {1'b0, r_mag_im[PROD_W-1:DATA_W]};
        n_div[0].sh_re  = r_mag_re[DATA_W-1:0];
        n_div[0].sh_im  = r_mag_im[DATA_W-1:0];
        n_div[0].neg_re = r_neg_re;
        n_div[0].neg_im = r_neg_im;
        n_div[0].ovf_re = ({1'b0, r_mag_re[PROD_W-1:DATA_W]} >= r_den[3]);
        n_div[0].ovf_im = ({1'b0, r_mag_im[PROD_W-1:DATA_W]} >= r_den[3]);
        for (int k = 1; k <= DIV_STEPS; k++) begin
            s_re = div_step(r_div[k-1].rem_re, r_div[k-1].sh_re, r_den[FRONT_STG+k-2]);
            s_im = div_step(r_div[k-1].rem_im, r_div[k-1].sh_im, r_den[FRONT_STG+k-2]);
            n_div[k]        = r_div[k-1];
            n_div[k].rem_re = s_re.rem;
            n_div[k].sh_re  = s_re.sh;
            n_div[k].rem_im = s_im.rem;
            n_div[k].sh_im  = s_im.sh;
        end
    end

    always_comb begin
        den_zero   = (r_den[NSTG-1] == '0);
        fin_re     = finish(r_div[DIV_STEPS].sh_re, r_div[DIV_STEPS].neg_re,
                            r_div[DIV_STEPS].ovf_re);
        fin_im     = finish(r_div[DIV_STEPS].sh_im, r_div[DIV_STEPS].neg_im,
                            r_div[DIV_STEPS].ovf_im);
        n_res.re   = den_zero ? '0 : fin_re[DATA_W-1:0];
        n_res.im   = den_zero ? '0 : fin_im[DATA_W-1:0];
        n_res.zero = den_zero;
        n_res.sat  = !den_zero && (fin_re[DATA_W] || fin_im[DATA_W]);
        n_res.last = r_last[NSTG-1];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond   <= COND_RESET;
            r_vld    <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cond <= i_cfg_wr_data;
            end
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], i_valid};
            end
            if (take_ok) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= r_vld[NSTG-1];
                end
            end else if (en && r_vld[NSTG-1]) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= i_image_real * i_spread_real;
            r_p1 <= i_image_imag * i_spread_imag;
            r_p2 <= $signed({1'b0, i_transfer_mag}) * i_estimate_real;
            r_p3 <= i_image_imag * i_spread_real;
            r_p4 <= i_image_real * i_spread_imag;
            r_p5 <= $signed({1'b0, i_transfer_mag}) * i_estimate_imag;
            r_den[0]  <= {2'b00, i_transfer_mag} + {1'b0, r_cond};
            r_last[0] <= i_last_bin;

            r_sa_re <= {r_p0[PROD_W-1], r_p0} + {r_p1[PROD_W-1], r_p1};
            r_sa_im <= {r_p3[PROD_W-1], r_p3} - {r_p4[PROD_W-1], r_p4};
            r_q2    <= r_p2;
            r_q5    <= r_p5;

            r_n_re <= {r_sa_re[PROD_W], r_sa_re} - {{2{r_q2[PROD_W-1]}}, r_q2};
            r_n_im <= {r_sa_im[PROD_W], r_sa_im} - {{2{r_q5[PROD_W-1]}}, r_q5};

            r_mag_re <= n_abs_re[PROD_W-1:0];
            r_mag_im <= n_abs_im[PROD_W-1:0];
            r_neg_re <= r_n_re[PROD_W+1];
            r_neg_im <= r_n_im[PROD_W+1];

            for (int k = 1; k < NSTG; k++) begin
                r_den[k]  <= r_den[k-1];
                r_last[k] <= r_last[k-1];
            end
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_div[k] <= n_div[k];
            end
        end
        if (take_ok) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (en) begin
            r_skid <= n_res;
        end
    end

    assign o_valid        = r_out_v;
    assign o_updated_real = r_out.re;
    assign o_updated_imag = r_out.im;
    assign o_zero_divisor = r_out.zero;
    assign o_saturated    = r_out.sat;
    assign o_last_out     = r_out.last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid register loaded without a stalled output");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_divisor) |->
            (o_updated_real == '0 && o_updated_imag == '0 && !o_saturated))
        else $error("zero divisor result not cleared");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_updated_real == POS_MAX || o_updated_real == NEG_MIN ||
             o_updated_imag == POS_MAX || o_updated_imag == NEG_MIN))
        else $error("saturation flag without a clipped value");

endmodule

// ===== bench/tb_frequency_domain_deconvolution_update.sv =====
// Testbench for the per-bin deconvolution update: random and directed bins, scoreboard check.
`timescale 1ns / 1ps

import fdd_pkg::*;

typedef struct {
    logic signed [DATA_W-1:0] img_re;
    logic signed [DATA_W-1:0] img_im;
    logic signed [DATA_W-1:0] psf_re;
    logic signed [DATA_W-1:0] psf_im;
    logic        [MAG_W-1:0]  tmag;
    logic signed [DATA_W-1:0] est_re;
    logic signed [DATA_W-1:0] est_im;
    logic                     last;
} t_bin;

class deconv_scoreboard;
    logic [DATA_W-1:0] cond;
    t_res              update_q[$];
    int unsigned       mismatches;

    function new();
        cond       = COND_RESET;
        mismatches = 0;
    endfunction

    // truncate toward zero, clip to 32-bit signed; returns {sat, value}
    function logic [DATA_W:0] clip_quotient(logic signed [67:0] num, logic [DEN_W-1:0] den);
        logic [67:0] mag;
        logic [67:0] quo;
        mag = (num < 0) ? -num : num;
        quo = mag / den;
        if (num < 0) begin
            if (quo > 68'h8000_0000)
                return {1'b1, NEG_MIN};
            return {1'b0, ~quo[DATA_W-1:0] + 32'd1};
        end
        if (quo > 68'h7FFF_FFFF)
            return {1'b1, POS_MAX};
        return {1'b0, quo[DATA_W-1:0]};
    endfunction

    function void note_request(t_bin b);
        logic signed [67:0] ir, ii, pr, pi, er, ei, tt, nr, ni;
        logic [DEN_W-1:0]   den;
        logic [DATA_W:0]    qr, qi;
        t_res               r;
        ir  = b.img_re;
        ii  = b.img_im;
        pr  = b.psf_re;
        pi  = b.psf_im;
        er  = b.est_re;
        ei  = b.est_im;
        tt  = {37'd0, b.tmag};
        den = {1'b0, cond} + {2'b00, b.tmag};
        r.last = b.last;
        if (den == '0) begin
            r.re   = '0;
            r.im   = '0;
            r.zero = 1'b1;
            r.sat  = 1'b0;
        end else begin
            // conj(P) * I - T * E
            nr     = ir * pr + ii * pi - tt * er;
            ni     = ii * pr - ir * pi - tt * ei;
            qr     = clip_quotient(nr, den);
            qi     = clip_quotient(ni, den);
            r.re   = qr[DATA_W-1:0];
            r.im   = qi[DATA_W-1:0];
            r.zero = 1'b0;
            r.sat  = qr[DATA_W] | qi[DATA_W];
        end
        update_q.push_back(r);
    endfunction

    function void check_result(t_res got);
        t_res exp_r;
        if (update_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result re=%h im=%h zero=%b sat=%b last=%b",
                         got.re, got.im, got.zero, got.sat, got.last);
            return;
        end
        exp_r = update_q.pop_front();
        if (got.re !== exp_r.re || got.im !== exp_r.im || got.zero !== exp_r.zero ||
            got.sat !== exp_r.sat || got.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("ERROR: exp re=%h im=%h zero=%b sat=%b last=%b, ",
                       exp_r.re, exp_r.im, exp_r.zero, exp_r.sat, exp_r.last);
                $display("got re=%h im=%h zero=%b sat=%b last=%b",
                         got.re, got.im, got.zero, got.sat, got.last);
            end
        end
    endfunction

    function int pending();
        return update_q.size();
    endfunction
endclass

module tb_frequency_domain_deconvolution_update;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 45;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BINS   = 205;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [DATA_W-1:0]        i_cfg_wr_data;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_image_real;
    logic signed [DATA_W-1:0] i_image_imag;
    logic signed [DATA_W-1:0] i_spread_real;
    logic signed [DATA_W-1:0] i_spread_imag;
    logic        [MAG_W-1:0]  i_transfer_mag;
    logic signed [DATA_W-1:0] i_estimate_real;
    logic signed [DATA_W-1:0] i_estimate_imag;
    logic                     i_last_bin;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_updated_real;
    logic signed [DATA_W-1:0] o_updated_imag;
    logic                     o_zero_divisor;
    logic                     o_saturated;
    logic                     o_last_out;

    deconv_scoreboard sb = new();
    int unsigned      cycle_count = 0;
    bit               tx_idle_on  = 1'b1;
    bit               rx_idle_on  = 1'b1;
    bit               hold_req    = 1'b0;

    frequency_domain_deconvolution_update i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_image_real    (i_image_real),
        .i_image_imag    (i_image_imag),
        .i_spread_real   (i_spread_real),
        .i_spread_imag   (i_spread_imag),
        .i_transfer_mag  (i_transfer_mag),
        .i_estimate_real (i_estimate_real),
        .i_estimate_imag (i_estimate_imag),
        .i_last_bin      (i_last_bin),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_updated_real  (o_updated_real),
        .o_updated_imag  (o_updated_imag),
        .o_zero_divisor  (o_zero_divisor),
        .o_saturated     (o_saturated),
        .o_last_out      (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            sb.check_result(t_res'{re: o_updated_real, im: o_updated_imag,
                                   zero: o_zero_divisor, sat: o_saturated,
                                   last: o_last_out});
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_word();
        logic [DATA_W-1:0] v;
        v = $urandom_range(0, 32'h3_FFFF);
        case ($urandom_range(0, 11))
            0:       return NEG_MIN;
            1:       return POS_MAX;
            2:       return '0;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return v - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [MAG_W-1:0] rand_mag();
        logic [DATA_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 31'd1;
            3, 4, 5: return 31'($urandom_range(0, 32'h3_FFFF));
            default: return v[MAG_W-1:0];
        endcase
    endfunction

    function automatic t_bin mk_bin(logic [31:0] ir, logic [31:0] ii, logic [31:0] pr,
                                    logic [31:0] pi, logic [30:0] t, logic [31:0] er,
                                    logic [31:0] ei, logic last);
        t_bin b;
        b.img_re = ir;
        b.img_im = ii;
        b.psf_re = pr;
        b.psf_im = pi;
        b.tmag   = t;
        b.est_re = er;
        b.est_im = ei;
        b.last   = last;
        return b;
    endfunction

    function automatic t_bin rand_bin();
        return mk_bin(rand_word(), rand_word(), rand_word(), rand_word(), rand_mag(),
                      rand_word(), rand_word(), $urandom_range(0, 15) == 0);
    endfunction

    task automatic send_bin(input t_bin b);
        i_valid         <= 1'b1;
        i_image_real    <= b.img_re;
        i_image_imag    <= b.img_im;
        i_spread_real   <= b.psf_re;
        i_spread_imag   <= b.psf_im;
        i_transfer_mag  <= b.tmag;
        i_estimate_real <= b.est_re;
        i_estimate_imag <= b.est_im;
        i_last_bin      <= b.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(b);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cond(input logic [DATA_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.cond = value;
    endtask

    logic [DATA_W-1:0] phase_cond [8];

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_valid         <= 1'b0;
        i_image_real    <= '0;
        i_image_imag    <= '0;
        i_spread_real   <= '0;
        i_spread_imag   <= '0;
        i_transfer_mag  <= '0;
        i_estimate_real <= '0;
        i_estimate_imag <= '0;
        i_last_bin      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset conditioning value
        send_bin(mk_bin(0, 0, 0, 0, 0, 0, 0, 0));
        send_bin(mk_bin(POS_MAX, POS_MAX, POS_MAX, POS_MAX, '1, POS_MAX, POS_MAX, 1));
        send_bin(mk_bin(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, 0, NEG_MIN, NEG_MIN, 0));
        send_bin(mk_bin(POS_MAX, 0, POS_MAX, 0, 0, 0, 0, 0));
        send_bin(mk_bin(NEG_MIN, 0, POS_MAX, 0, 0, 0, 0, 0));
        // negative quotient truncating to zero
        send_bin(mk_bin(32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 1));
        send_bin(mk_bin(32'h0001_0000, 32'h0000_8000, 32'h0000_CCCD, 32'hFFFF_CCCD,
                        31'h0000_AE14, 32'h0000_4CCD, 32'hFFFF_E666, 0));
        send_bin(mk_bin(0, 0, 0, 0, '1, NEG_MIN, POS_MAX, 1));
        drain_pipe();

        write_cond('0);
        send_bin(mk_bin(32'h1234_5678, NEG_MIN, POS_MAX, 32'h0001_0000, 0, 5, 7, 1));
        send_bin(mk_bin(NEG_MIN, 0, 1, 0, 1, 0, 0, 0));
        send_bin(mk_bin(NEG_MIN, 0, 1, 0, 1, 1, 0, 0));
        send_bin(mk_bin(0, 0, 0, 0, 1, NEG_MIN, 0, 0));
        send_bin(mk_bin(0, 0, 0, 0, 1, 32'h8000_0001, 32'h8000_0001, 1));
        drain_pipe();

        write_cond(32'hFFFF_FFFF);
        send_bin(mk_bin(POS_MAX, POS_MAX, POS_MAX, POS_MAX, '1, POS_MAX, POS_MAX, 0));
        send_bin(mk_bin(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, 0, NEG_MIN, NEG_MIN, 1));
        drain_pipe();

        phase_cond[0] = '0;
        phase_cond[1] = 32'hFFFF_FFFF;
        phase_cond[2] = 32'd1;
        phase_cond[3] = 32'h0001_0000;
        phase_cond[4] = $urandom_range(0, 32'h000F_FFFF);
        phase_cond[5] = $urandom();
        phase_cond[6] = $urandom_range(0, 32'h0000_FFFF);
        phase_cond[7] = COND_RESET;
        for (int p = 0; p < 8; p++) begin
            write_cond(phase_cond[p]);
            tx_idle_on = (p != 5) && (p != 7);
            rx_idle_on = (p != 7);
            if (p == 5)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_BINS; n++)
                send_bin(rand_bin());
            drain_pipe();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fdd_pkg.sv
design/frequency_domain_deconvolution_update.sv
bench/tb_frequency_domain_deconvolution_update.sv
